### rtl/nct_pkg.sv
package nct_pkg;

    // fixed field widths
    localparam int COORD_BITS = 12;
    localparam int ID_BITS    = 16;
    localparam int COUNT_BITS = 6;

    // squared distance: sum of two squares of COORD_BITS-bit values
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;

    // stream packing
    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = ((ID_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    // tuser bit positions
    localparam int IN_USER_KIND     = 0;
    localparam int OUT_USER_MATCHED = 0;
    localparam int OUT_USER_FULL    = 1;

    localparam logic [COORD_BITS-1:0] RADIUS_RESET = COORD_BITS'(50);

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } entry_t;

    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] dist_sq;
        logic [ID_BITS-1:0] id;
    } best_t;

endpackage

### rtl/nct_nearest.sv
module nct_nearest #(
    parameter int SLOT_W = 5
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic                          in_vld,
    input  logic [SLOT_W-1:0]             in_slot,
    input  nct_pkg::entry_t               in_entry,
    input  logic [nct_pkg::COORD_BITS-1:0] det_x,
    input  logic [nct_pkg::COORD_BITS-1:0] det_y,
    output nct_pkg::best_t                best,
    output logic [SLOT_W-1:0]             best_slot
);
    import nct_pkg::*;

    // stage B: absolute differences
    logic                  b_vld_reg;
    logic [SLOT_W-1:0]     b_slot_reg;
    logic [ID_BITS-1:0]    b_id_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;

    // stage C: squares
    logic                  c_vld_reg;
    logic [SLOT_W-1:0]     c_slot_reg;
    logic [ID_BITS-1:0]    c_id_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;

    // stage D: running minimum
    best_t             best_reg;
    logic [SLOT_W-1:0] best_slot_reg;
    logic [DIST_W-1:0] sum;

    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg      <= 1'b0;
            c_vld_reg      <= 1'b0;
            best_reg.found <= 1'b0;
        end else begin
            b_vld_reg <= in_vld;
            c_vld_reg <= b_vld_reg;
            if (clear) begin
                best_reg.found <= 1'b0;
            end else if (c_vld_reg && (!best_reg.found || sum < best_reg.dist_sq)) begin
                // strict compare: slots arrive in ascending order, lowest wins ties
                best_reg.found <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b_slot_reg <= in_slot;
        b_id_reg   <= in_entry.id;
        dx_reg     <= (det_x >= in_entry.x) ? det_x - in_entry.x : in_entry.x - det_x;
        dy_reg     <= (det_y >= in_entry.y) ? det_y - in_entry.y : in_entry.y - det_y;

        c_slot_reg <= b_slot_reg;
        c_id_reg   <= b_id_reg;
        sqx_reg    <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg    <= SQ_W'(dy_reg) * SQ_W'(dy_reg);

        if (!clear && c_vld_reg && (!best_reg.found || sum < best_reg.dist_sq)) begin
            best_reg.dist_sq <= sum;
            best_reg.id      <= c_id_reg;
            best_slot_reg    <= c_slot_reg;
        end
    end

    assign best      = best_reg;
    assign best_slot = best_slot_reg;

endmodule

### rtl/nearest_centroid_tracker.sv
// Nearest-centroid object tracker.
// Input stream: one transfer per detection centre (tuser kind = 0) and one
// end-of-frame transfer (kind = 1) after the last detection of a frame.
// Output stream: exactly one transfer per input transfer, in order. A
// detection gets the ID of the nearest tracked object when that object lies
// strictly inside match_radius (matched = 1), else a fresh ID from a
// wrapping counter; no ID but table_full = 1 if the next table is full. tlast
// marks the end-of-frame result, which carries the number of objects now tracked.
// Config channel: writes match_radius; write only while the block is idle.
// Operation: a detection walks the current object table one slot per cycle
// through a shared distance/minimum pipeline; the block takes no new input
// until the last result is committed to the output register. End of frame
// and a detection that finds the next table full skip the table walk.
// Reset (aresetn low, synchronous): both tables empty, ID counter zero,
// radius 50. No clearing pass is needed; the block is ready at once.
// A stalled receiver holds the result in the output register; the block
// finishes the next item's search meanwhile and waits to commit it.
module nearest_centroid_tracker #(
    parameter int TABLE_SLOTS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: match_radius
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nct_pkg::COORD_BITS-1:0] cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nct_pkg::IN_DATA_W-1:0]  s_tdata,  // center_x, center_y
    input  logic [nct_pkg::IN_USER_W-1:0]  s_tuser,  // kind
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nct_pkg::OUT_DATA_W-1:0] m_tdata,  // object_id, tracked_count, zero pad
    output logic [nct_pkg::OUT_USER_W-1:0] m_tuser,  // matched, table_full
    output logic                           m_tlast   // frame_done
);
    import nct_pkg::*;

    localparam int SLOT_W    = $clog2(TABLE_SLOTS);
    localparam int FILL_W    = $clog2(TABLE_SLOTS + 1);
    localparam int STEP_W    = $clog2(TABLE_SLOTS + 3);
    localparam int ADDR_W    = SLOT_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int LAST_STEP = TABLE_SLOTS + 2;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg;
    logic                  bank_reg;      // which half of the memory is the current table
    logic [FILL_W-1:0]     fill_reg;      // entries in the next table
    logic [ID_BITS-1:0]    issue_reg;
    logic [COORD_BITS-1:0] radius_reg;
    logic [SQ_W-1:0]       radius_sq_reg;
    logic                  cur_valid_reg [TABLE_SLOTS];
    logic [COORD_BITS-1:0] det_x_reg, det_y_reg;
    logic                  eof_reg, full_reg;

    // both tables share one memory, halves swapped at end of frame
    entry_t                mem [MEM_DEPTH];
    entry_t                rd_entry_reg;
    logic                  a_vld_reg;
    logic [SLOT_W-1:0]     a_slot_reg;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_USER_W-1:0] m_tuser_reg;
    logic                  m_tlast_reg;

    logic                  in_xfer, out_free, commit, issue, matched;
    logic [SLOT_W-1:0]     slot;
    logic [ADDR_W-1:0]     rd_addr, wr_addr;
    logic [ID_BITS-1:0]    new_id;
    entry_t                wr_entry;
    best_t                 best;
    logic [SLOT_W-1:0]     best_slot;
    logic [OUT_DATA_W-1:0] out_data;
    logic [OUT_USER_W-1:0] out_user;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign commit    = (state_reg == ST_COMMIT) && out_free;

    assign issue   = (state_reg == ST_SCAN) && (step_reg < STEP_W'(TABLE_SLOTS));
    assign slot    = step_reg[SLOT_W-1:0];
    assign rd_addr = {bank_reg, slot};
    assign wr_addr = {~bank_reg, fill_reg[SLOT_W-1:0]};

    assign matched = !eof_reg && !full_reg && best.found &&
                     ({1'b0, radius_sq_reg} > best.dist_sq);
    assign new_id  = matched ? best.id : issue_reg;

    always_comb begin
        wr_entry.id = new_id;
        wr_entry.x  = det_x_reg;
        wr_entry.y  = det_y_reg;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser[IN_USER_KIND] || (fill_reg == FILL_W'(TABLE_SLOTS))) begin
                        state_next = ST_COMMIT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (step_reg == STEP_W'(LAST_STEP)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bank_reg     <= 1'b0;
            fill_reg     <= '0;
            issue_reg    <= '0;
            radius_reg   <= RADIUS_RESET;
            a_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                cur_valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            a_vld_reg <= issue && cur_valid_reg[slot];
            if (cfg_valid) begin
                radius_reg <= cfg_data;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
                if (eof_reg) begin
                    // next table becomes current; it was filled from slot 0 upwards
                    bank_reg <= ~bank_reg;
                    fill_reg <= '0;
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        cur_valid_reg[i] <= (FILL_W'(i) < fill_reg);
                    end
                end else if (!full_reg) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                    if (matched) begin
                        cur_valid_reg[best_slot] <= 1'b0;
                    end else begin
                        issue_reg <= issue_reg + ID_BITS'(1);
                    end
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        radius_sq_reg <= SQ_W'(radius_reg) * SQ_W'(radius_reg);
        if (in_xfer) begin
            eof_reg   <= s_tuser[IN_USER_KIND];
            det_x_reg <= s_tdata[COORD_BITS-1:0];
            det_y_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            full_reg  <= (fill_reg == FILL_W'(TABLE_SLOTS));
            step_reg  <= '0;
        end else if (state_reg == ST_SCAN) begin
            step_reg <= step_reg + STEP_W'(1);
        end
        a_slot_reg <= slot;
        if (commit) begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= out_user;
            m_tlast_reg <= eof_reg;
        end
    end

    // object tables
    always_ff @(posedge aclk) begin
        if (commit && !eof_reg && !full_reg) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
    end

    always_comb begin
        out_data = '0;
        out_user = '0;
        if (eof_reg) begin
            out_data[ID_BITS +: COUNT_BITS] = COUNT_BITS'(fill_reg);
        end else if (full_reg) begin
            out_user[OUT_USER_FULL] = 1'b1;
        end else begin
            out_data[ID_BITS-1:0]       = new_id;
            out_user[OUT_USER_MATCHED]  = matched;
        end
    end

    nct_nearest #(
        .SLOT_W (SLOT_W)
    ) u_nearest (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (in_xfer),
        .in_vld    (a_vld_reg),
        .in_slot   (a_slot_reg),
        .in_entry  (rd_entry_reg),
        .det_x     (det_x_reg),
        .det_y     (det_y_reg),
        .best      (best),
        .best_slot (best_slot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/nct_checker.sv
module nct_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nct_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [nct_pkg::OUT_USER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import nct_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // one item at a time: busy straight after a transfer in
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // end-of-frame result carries no ID and no flags
    a_eof_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[ID_BITS-1:0] == '0) && (m_tuser == '0))
        else $error("end-of-frame result has ID or flags");

    // detection result carries no count, and a full table gives no ID
    a_det_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[ID_BITS +: COUNT_BITS] == '0) &&
            (!m_tuser[OUT_USER_FULL] ||
             ((m_tdata[ID_BITS-1:0] == '0) && !m_tuser[OUT_USER_MATCHED])))
        else $error("detection result fields inconsistent");

endmodule

bind nearest_centroid_tracker nct_checker u_nct_checker (.*);
